// ----- src/union_find_set_table_defines.svh -----
// Assertion helpers shared by the set table RTL.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef UNION_FIND_SET_TABLE_DEFINES_SVH
`define UNION_FIND_SET_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UFT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("set table: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define UFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("set table: assertion failed");

`endif

// ----- src/uft_pkg.sv -----
`default_nettype none

package uft_pkg;

	localparam int ELEM_W = 8;
	localparam int ROOT_W = 8;
	localparam int SIZE_W = 9;

	localparam logic FUNC_FIND  = 1'b0;
	localparam logic FUNC_UNION = 1'b1;

	typedef struct packed {
		logic              func;
		logic [ELEM_W-1:0] first;
		logic [ELEM_W-1:0] second;
	} op_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root_first;
		logic [ROOT_W-1:0] root_second;
		logic [ROOT_W-1:0] final_root;
		logic [SIZE_W-1:0] final_size;
		logic              already_joined;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND_A,
		ST_FIND_B,
		ST_COMP_A,
		ST_COMP_B,
		ST_LINK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- src/union_find_set_table.sv -----
// Disjoint-set table: weighted quick-union with path compression.
// Input channel op (op_valid/op_stall) carries func, first and second.
// Find (func 0) reports the root of first and leaves the table alone.
// Union (func 1) joins the sets of first and second; if they differ, it compresses both paths.
// Result channel res (res_valid/res_stall) returns one transfer per operation.
// Timing is set by the parent-chain walk through the parent memory, one
// link per cycle through its registered read port.
// A find walks the chain of first; a union then walks the chain of second
// and, unless both roots match, rewrites both paths and links the roots.
// Depths stay small because every union of two separate sets flattens the walked paths.
// One operation is in flight at a time; the next is accepted once the
// result has moved into the output register, which holds it while res_stall is high.
// After reset, a clearing pass initializes both memories with op_stall
// high; no operation is accepted before it ends.
`default_nettype none

module union_find_set_table #(
	parameter int NUM_ELEMENTS = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         op_valid,
	output logic              op_stall,
	input  wire uft_pkg::op_t op,
	output logic              res_valid,
	input  wire logic         res_stall,
	output uft_pkg::res_t     res
);

	localparam int IDX_W = $clog2(NUM_ELEMENTS);
	localparam int SZ_W  = $clog2(NUM_ELEMENTS + 1);

	logic              p_we, s_we;
	logic [IDX_W-1:0]  p_waddr, p_wdata, p_rdata, s_waddr, rd_addr;
	logic [SZ_W-1:0]   s_wdata, s_rdata;
	logic              core_valid, core_take;
	uft_pkg::res_t     core_res;
	logic              res_valid_q;
	uft_pkg::res_t     res_q;

	uft_ram #(.DEPTH(NUM_ELEMENTS), .AW(IDX_W), .DW(IDX_W)) u_parent (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (rd_addr),
		.rdata (p_rdata)
	);

	uft_ram #(.DEPTH(NUM_ELEMENTS), .AW(IDX_W), .DW(SZ_W)) u_size (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (rd_addr),
		.rdata (s_rdata)
	);

	uft_ctrl #(.NUM_ELEMENTS(NUM_ELEMENTS), .IDX_W(IDX_W), .SZ_W(SZ_W)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op        (op),
		.res_valid (core_valid),
		.res_take  (core_take),
		.res       (core_res),
		.p_we      (p_we),
		.p_waddr   (p_waddr),
		.p_wdata   (p_wdata),
		.p_rdata   (p_rdata),
		.s_we      (s_we),
		.s_waddr   (s_waddr),
		.s_wdata   (s_wdata),
		.s_rdata   (s_rdata),
		.rd_addr   (rd_addr)
	);

	assign core_take = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (core_take) begin
			res_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_take && core_valid) begin
			res_q <= core_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ----- src/uft_ram.sv -----
`default_nettype none

module uft_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/uft_ctrl.sv -----
`default_nettype none
`include "union_find_set_table_defines.svh"

module uft_ctrl #(
	parameter int NUM_ELEMENTS = 256,
	parameter int IDX_W        = 8,
	parameter int SZ_W         = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              op_valid,
	output logic                   op_stall,
	input  wire uft_pkg::op_t      op,
	output logic                   res_valid,
	input  wire logic              res_take,
	output uft_pkg::res_t          res,
	output logic                   p_we,
	output logic      [IDX_W-1:0]  p_waddr,
	output logic      [IDX_W-1:0]  p_wdata,
	input  wire logic [IDX_W-1:0]  p_rdata,
	output logic                   s_we,
	output logic      [IDX_W-1:0]  s_waddr,
	output logic      [SZ_W-1:0]   s_wdata,
	input  wire logic [SZ_W-1:0]   s_rdata,
	output logic      [IDX_W-1:0]  rd_addr
);

	localparam int                 TAB_DEPTH = 2 ** uft_pkg::ELEM_W;
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NUM_ELEMENTS - 1);

	uft_pkg::state_t   state_q, state_d;
	logic [IDX_W-1:0]  cnt_q;
	logic              func_q;
	logic [IDX_W-1:0]  a_q, b_q, cur_q, ra_q, rb_q, win_q, lose_q;
	logic [SZ_W-1:0]   sa_q, sum_q;
	uft_pkg::res_t     res_q;

	logic [IDX_W-1:0]  mod_tab [TAB_DEPTH];
	logic [IDX_W-1:0]  a_in, b_in;
	logic              found;

	// Element indices wrap modulo NUM_ELEMENTS; the lookup table is fixed at elaboration.
	for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_mod
		assign mod_tab[g] = IDX_W'(g % NUM_ELEMENTS);
	end

	assign a_in  = mod_tab[op.first];
	assign b_in  = mod_tab[op.second];
	assign found = (p_rdata == cur_q);
	assign res   = res_q;

	function automatic logic [uft_pkg::ROOT_W-1:0] to_root(input logic [IDX_W-1:0] r);
		logic [IDX_W+uft_pkg::ROOT_W-1:0] w;
		w = {{uft_pkg::ROOT_W{1'b0}}, r};
		return w[uft_pkg::ROOT_W-1:0];
	endfunction

	function automatic logic [uft_pkg::SIZE_W-1:0] to_size(input logic [SZ_W-1:0] s);
		logic [SZ_W+uft_pkg::SIZE_W-1:0] w;
		w = {{uft_pkg::SIZE_W{1'b0}}, s};
		return w[uft_pkg::SIZE_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uft_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == uft_pkg::ST_CLEAR) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		op_stall  = 1'b1;
		res_valid = 1'b0;
		p_we      = 1'b0;
		p_waddr   = cur_q;
		p_wdata   = win_q;
		s_we      = 1'b0;
		s_waddr   = win_q;
		s_wdata   = sum_q;
		rd_addr   = cur_q;
		case (state_q)
			uft_pkg::ST_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = cnt_q;
				p_wdata = cnt_q;
				s_we    = 1'b1;
				s_waddr = cnt_q;
				s_wdata = SZ_W'(1);
				if (cnt_q == LAST_IDX) begin
					state_d = uft_pkg::ST_IDLE;
				end
			end
			uft_pkg::ST_IDLE: begin
				op_stall = 1'b0;
				rd_addr  = a_in;
				if (op_valid) begin
					state_d = uft_pkg::ST_FIND_A;
				end
			end
			uft_pkg::ST_FIND_A: begin
				if (!found) begin
					rd_addr = p_rdata;
				end else if (func_q == uft_pkg::FUNC_UNION) begin
					rd_addr = b_q;
					state_d = uft_pkg::ST_FIND_B;
				end else begin
					state_d = uft_pkg::ST_DONE;
				end
			end
			uft_pkg::ST_FIND_B: begin
				if (!found) begin
					rd_addr = p_rdata;
				end else if (cur_q == ra_q) begin
					state_d = uft_pkg::ST_DONE;
				end else begin
					rd_addr = a_q;
					state_d = uft_pkg::ST_COMP_A;
				end
			end
			uft_pkg::ST_COMP_A: begin
				if (cur_q == ra_q) begin
					rd_addr = b_q;
					state_d = uft_pkg::ST_COMP_B;
				end else begin
					p_we    = 1'b1;
					rd_addr = p_rdata;
				end
			end
			uft_pkg::ST_COMP_B: begin
				if (cur_q == rb_q) begin
					state_d = uft_pkg::ST_LINK;
				end else begin
					p_we    = 1'b1;
					rd_addr = p_rdata;
				end
			end
			uft_pkg::ST_LINK: begin
				p_we    = 1'b1;
				p_waddr = lose_q;
				s_we    = 1'b1;
				state_d = uft_pkg::ST_DONE;
			end
			uft_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = uft_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = uft_pkg::ST_IDLE;
			end
		endcase
	end

	// The parent of cur_q arrives on p_rdata in the cycle after its address was issued.
	always_ff @(posedge clk) begin
		case (state_q)
			uft_pkg::ST_IDLE: begin
				if (op_valid) begin
					func_q <= op.func;
					a_q    <= a_in;
					b_q    <= b_in;
					cur_q  <= a_in;
				end
			end
			uft_pkg::ST_FIND_A: begin
				if (found) begin
					ra_q                 <= cur_q;
					sa_q                 <= s_rdata;
					cur_q                <= b_q;
					res_q.root_first     <= to_root(cur_q);
					res_q.root_second    <= to_root(cur_q);
					res_q.final_root     <= to_root(cur_q);
					res_q.final_size     <= to_size(s_rdata);
					res_q.already_joined <= 1'b0;
				end else begin
					cur_q <= p_rdata;
				end
			end
			uft_pkg::ST_FIND_B: begin
				if (found) begin
					rb_q              <= cur_q;
					cur_q             <= a_q;
					res_q.root_second <= to_root(cur_q);
					sum_q             <= sa_q + s_rdata;
					if (sa_q < s_rdata) begin
						win_q  <= cur_q;
						lose_q <= ra_q;
					end else begin
						win_q  <= ra_q;
						lose_q <= cur_q;
					end
					if (cur_q == ra_q) begin
						res_q.already_joined <= 1'b1;
					end
				end else begin
					cur_q <= p_rdata;
				end
			end
			uft_pkg::ST_COMP_A: begin
				if (cur_q == ra_q) begin
					cur_q <= b_q;
				end else begin
					cur_q <= p_rdata;
				end
			end
			uft_pkg::ST_COMP_B: begin
				if (cur_q != rb_q) begin
					cur_q <= p_rdata;
				end
			end
			uft_pkg::ST_LINK: begin
				res_q.final_root <= to_root(win_q);
				res_q.final_size <= to_size(sum_q);
			end
			default: begin
			end
		endcase
	end

	`UFT_ASSERT_IMPL(a_idle_no_write, state_q == uft_pkg::ST_IDLE, !p_we && !s_we)
	`UFT_ASSERT_IMPL(a_comp_keeps_root, p_we && (state_q == uft_pkg::ST_COMP_A), cur_q != ra_q)
	`UFT_ASSERT_IMPL(a_find_roots_match, res_valid && (func_q == uft_pkg::FUNC_FIND), (res.root_first == res.root_second) && !res.already_joined)
	`UFT_ASSERT_IMPL(a_no_rw_collision, p_we && (state_q != uft_pkg::ST_CLEAR) && (state_q != uft_pkg::ST_LINK), p_waddr != rd_addr)
	`UFT_ASSERT_NEXT(a_accept_starts_walk, op_valid && !op_stall, state_q == uft_pkg::ST_FIND_A)

endmodule

`default_nettype wire
